>>> design/mqsm_pkg.sv
`timescale 1ns / 1ps
package mqsm_pkg;
	localparam int QUEUES = 4;
	localparam int QUEUE_DEPTH = 256;
	localparam int SLOTS = 256;
	localparam int FRAME_BYTES = 512;
	localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int SW = $clog2(SLOTS);
	localparam int RW = QW + PW;

	localparam logic [1:0] CMD_PUSH = 2'd0;
	localparam logic [1:0] CMD_POP = 2'd1;
	localparam logic [1:0] CMD_TEST = 2'd2;
	localparam logic [1:0] CMD_CLEAR = 2'd3;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_BAD_QUEUE = 3'd1;
	localparam logic [2:0] ST_TOO_LONG = 3'd2;
	localparam logic [2:0] ST_NO_SLOT = 3'd3;
	localparam logic [2:0] ST_QUEUE_FULL = 3'd4;
	localparam logic [2:0] ST_QUEUE_EMPTY = 3'd5;

	typedef struct packed {
		logic [1:0] cmd;
		logic [2:0] queue_sel;
		logic [9:0] length_in;
		logic [7:0] stamp_in;
		logic [7:0] packet_count;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] slot;
		logic [16:0] byte_address;
		logic [9:0] length_out;
		logic [7:0] stamp_out;
		logic space_ok;
		logic [8:0] queue_fill;
		logic [8:0] total_fill;
	} out_item_t;

	// Command after classification by the front part.
	typedef struct packed {
		logic [1:0] cmd;
		logic bad_queue;
		logic too_long;
		logic [QW-1:0] q;
		logic [9:0] length;
		logic [7:0] stamp;
		logic [7:0] count;
	} work_t;
endpackage

>>> design/mqsm_front.sv
`timescale 1ns / 1ps
module mqsm_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input mqsm_pkg::in_item_t in_item,
	output logic wq_valid,
	input logic wq_ready,
	output mqsm_pkg::work_t wq_item
);
	// Two-entry queue between classification and execution.
	mqsm_pkg::work_t buf_q [2];
	logic [1:0] cnt_q;
	logic wr_q, rd_q;
	mqsm_pkg::work_t w;
	logic push, pop;

	always_comb begin
		w.cmd = in_item.cmd;
		w.bad_queue = ({29'd0, in_item.queue_sel} >= 32'(mqsm_pkg::QUEUES));
		w.too_long = ({22'd0, in_item.length_in} > 32'(mqsm_pkg::FRAME_BYTES));
		w.q = in_item.queue_sel[mqsm_pkg::QW-1:0];
		w.length = in_item.length_in;
		w.stamp = in_item.stamp_in;
		w.count = in_item.packet_count;
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign wq_valid = (cnt_q != 2'd0);
	assign pop = wq_valid && wq_ready;
	assign wq_item = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q <= 1'b0;
			rd_q <= 1'b0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

>>> design/mqsm_back.sv
`timescale 1ns / 1ps
module mqsm_back (
	input logic clk,
	input logic arst_n,
	input logic wq_valid,
	output logic wq_ready,
	input mqsm_pkg::work_t wq_item,
	output logic out_valid,
	input logic out_ready,
	output mqsm_pkg::out_item_t out_item
);
	typedef enum logic [1:0] {S_IDLE, S_SLOT, S_EXEC} state_t;
	localparam int SCNT = mqsm_pkg::SLOTS;

	state_t state_q;
	mqsm_pkg::work_t cur_q;
	logic [SCNT-1:0] busy_q;
	logic [mqsm_pkg::PW-1:0] wptr_q [mqsm_pkg::QUEUES];
	logic [mqsm_pkg::PW-1:0] rptr_q [mqsm_pkg::QUEUES];
	logic [8:0] qcnt_q [mqsm_pkg::QUEUES];
	logic [8:0] pool_q;
	logic [mqsm_pkg::SW-1:0] free_s1;
	logic free_ok_s1;
	logic [7:0] ring_mem [mqsm_pkg::QUEUES*mqsm_pkg::QUEUE_DEPTH];
	logic [9:0] len_mem [SCNT];
	logic [7:0] stamp_mem [SCNT];
	logic [7:0] ring_rd_q;
	logic [9:0] len_rd_q;
	logic [7:0] stamp_rd_q;

	logic [mqsm_pkg::SW-1:0] free_c;
	logic free_ok_c;
	always_comb begin
		free_c = '0;
		free_ok_c = 1'b0;
		for (int i = SCNT - 1; i >= 0; i--) begin
			if (!busy_q[i]) begin
				free_c = mqsm_pkg::SW'(i);
				free_ok_c = 1'b1;
			end
		end
	end

	// A result beat that leaves in this cycle frees the output register for the next command.
	logic take;
	assign wq_ready = (state_q == S_IDLE) && (!out_valid || out_ready);
	assign take = wq_valid && wq_ready;

	logic [mqsm_pkg::RW-1:0] rd_addr;
	assign rd_addr = {wq_item.q, rptr_q[wq_item.q]};

	logic [mqsm_pkg::SW-1:0] pslot;
	assign pslot = ring_rd_q[mqsm_pkg::SW-1:0];

	logic [8:0] qc;
	assign qc = qcnt_q[cur_q.q];
	logic do_push, do_pop;
	assign do_push = (cur_q.cmd == mqsm_pkg::CMD_PUSH) && !cur_q.bad_queue && !cur_q.too_long
		&& free_ok_s1 && ({23'd0, qc} < 32'(mqsm_pkg::QUEUE_DEPTH));
	assign do_pop = (cur_q.cmd == mqsm_pkg::CMD_POP) && !cur_q.bad_queue && (qc != 9'd0);

	// The ring entry is read when the command is taken; the length and stamp of the
	// slot it names are read in the following cycle, in state S_SLOT.
	always_ff @(posedge clk) begin
		if (take) begin
			ring_rd_q <= ring_mem[rd_addr];
		end
		if (state_q == S_SLOT) begin
			len_rd_q <= len_mem[pslot];
			stamp_rd_q <= stamp_mem[pslot];
		end
		if (state_q == S_EXEC && do_push) begin
			ring_mem[{cur_q.q, wptr_q[cur_q.q]}] <= 8'(free_s1);
			len_mem[free_s1] <= cur_q.length;
			stamp_mem[free_s1] <= cur_q.stamp;
		end
	end

	logic [8:0] qc_new, pool_new;
	always_comb begin
		qc_new = qc;
		pool_new = pool_q;
		if (do_push) begin
			qc_new = qc + 9'd1;
			pool_new = pool_q + 9'd1;
		end else if (do_pop) begin
			qc_new = qc - 9'd1;
			if (pool_q != 9'd0) pool_new = pool_q - 9'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
			out_item <= '0;
			cur_q <= '0;
			busy_q <= '0;
			pool_q <= '0;
			free_s1 <= '0;
			free_ok_s1 <= 1'b0;
			for (int i = 0; i < mqsm_pkg::QUEUES; i++) begin
				wptr_q[i] <= '0;
				rptr_q[i] <= '0;
				qcnt_q[i] <= '0;
			end
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						cur_q <= wq_item;
						free_s1 <= free_c;
						free_ok_s1 <= free_ok_c;
						state_q <= S_SLOT;
					end
				end
				S_SLOT: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_IDLE;
					out_valid <= 1'b1;
					out_item <= '0;
					out_item.status <= mqsm_pkg::ST_OK;
					if (cur_q.cmd == mqsm_pkg::CMD_CLEAR) begin
						busy_q <= '0;
						pool_q <= '0;
						for (int i = 0; i < mqsm_pkg::QUEUES; i++) begin
							wptr_q[i] <= '0;
							rptr_q[i] <= '0;
							qcnt_q[i] <= '0;
						end
						out_item.total_fill <= '0;
					end else if (cur_q.bad_queue) begin
						out_item.status <= mqsm_pkg::ST_BAD_QUEUE;
						out_item.total_fill <= pool_q;
					end else begin
						out_item.queue_fill <= qc_new;
						out_item.total_fill <= pool_new;
						qcnt_q[cur_q.q] <= qc_new;
						pool_q <= pool_new;
						case (cur_q.cmd)
							mqsm_pkg::CMD_PUSH: begin
								if (cur_q.too_long) out_item.status <= mqsm_pkg::ST_TOO_LONG;
								else if (!free_ok_s1) out_item.status <= mqsm_pkg::ST_NO_SLOT;
								else if (!do_push) out_item.status <= mqsm_pkg::ST_QUEUE_FULL;
								else begin
									busy_q[free_s1] <= 1'b1;
									wptr_q[cur_q.q] <= wptr_q[cur_q.q] + mqsm_pkg::PW'(1);
									out_item.slot <= 8'(free_s1);
									out_item.byte_address <=
										17'(free_s1) * 17'(mqsm_pkg::FRAME_BYTES);
								end
							end
							mqsm_pkg::CMD_POP: begin
								if (!do_pop) out_item.status <= mqsm_pkg::ST_QUEUE_EMPTY;
								else begin
									busy_q[pslot] <= 1'b0;
									rptr_q[cur_q.q] <= rptr_q[cur_q.q] + mqsm_pkg::PW'(1);
									out_item.slot <= 8'(pslot);
									out_item.byte_address <=
										17'(pslot) * 17'(mqsm_pkg::FRAME_BYTES);
									out_item.length_out <= len_rd_q;
									out_item.stamp_out <= stamp_rd_q;
								end
							end
							default: begin
								out_item.space_ok <=
									({23'd0, qc} + {24'd0, cur_q.count}
										<= 32'(mqsm_pkg::QUEUE_DEPTH))
									&& ({23'd0, pool_q} + {24'd0, cur_q.count}
										<= 32'(mqsm_pkg::SLOTS));
							end
						endcase
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> design/multi_queue_slot_manager_core.sv
`timescale 1ns / 1ps
// Shared frame-slot pool spread over FIFO queues. Each command beat gives one
// result beat. The back end handles one command at a time. In S_IDLE it captures
// the command, the lowest free slot and the ring entry; in S_SLOT it reads the
// length and stamp of the slot that entry names; in S_EXEC it updates the state
// and registers the result. It takes the next command in the cycle its result
// beat leaves, and not before the last result is registered; a stalled result
// beat holds the back end, while a two-entry queue in front keeps accepting up
// to two more command beats.
module multi_queue_slot_manager_core (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input mqsm_pkg::in_item_t in_item,
	output logic out_valid,
	input logic out_ready,
	output mqsm_pkg::out_item_t out_item
);
	logic wq_valid, wq_ready;
	mqsm_pkg::work_t wq_item;

	mqsm_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_item(in_item), .wq_valid(wq_valid), .wq_ready(wq_ready), .wq_item(wq_item)
	);

	mqsm_back u_back (
		.clk(clk), .arst_n(arst_n), .wq_valid(wq_valid), .wq_ready(wq_ready),
		.wq_item(wq_item), .out_valid(out_valid), .out_ready(out_ready),
		.out_item(out_item)
	);
endmodule

>>> design/mqsm_checker.sv
`timescale 1ns / 1ps
module mqsm_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input mqsm_pkg::out_item_t out_item
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result beat dropped or changed");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.queue_fill <= out_item.total_fill)
		else $error("queue fill above total");
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status != mqsm_pkg::ST_OK |-> out_item.slot == 8'd0)
		else $error("slot on a refused command");
endmodule

bind multi_queue_slot_manager_core mqsm_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_ready(out_ready),
	.out_item(out_item)
);
